@@ src/pls_pkg.sv @@
// Shared types, constants and codes for the positional list store.
package pls_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W      = ((CNT_W > 8) ? CNT_W : 8) + 1;

	localparam logic [2:0] REQ_INS_FIRST = 3'd0;
	localparam logic [2:0] REQ_INS_LAST  = 3'd1;
	localparam logic [2:0] REQ_INS_POS   = 3'd2;
	localparam logic [2:0] REQ_DEL_FIRST = 3'd3;
	localparam logic [2:0] REQ_DEL_LAST  = 3'd4;
	localparam logic [2:0] REQ_READ_POS  = 3'd5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic        [2:0]  req_type;
		logic signed [31:0] value;
		logic        [7:0]  position;
	} pls_req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic        [4:0]  count;
		logic signed [31:0] read_value;
	} pls_rsp_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} pls_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} pls_cmd_t;

endpackage

@@ src/pls_ctrl.sv @@
// Controller: sequences capture and execution of one item and raises the result strobe.
module pls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output pls_pkg::pls_cmd_t cmd
);
	import pls_pkg::*;

	pls_state_t state_q, state_d;
	logic       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			S_IDLE: cmd.load = start;
			S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

	assign done = done_q;

endmodule

@@ src/pls_dp.sv @@
// Datapath: shifting cell chain, occupancy counter, request checks and result register.
module pls_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  pls_pkg::pls_cmd_t cmd,
	input  pls_pkg::pls_req_t req,
	output pls_pkg::pls_rsp_t rsp
);
	import pls_pkg::*;

	pls_req_t                      req_q;
	logic     [DATA_WIDTH-1:0]     cells_q [DEPTH];
	logic     [CNT_W-1:0]          occ_q;
	pls_rsp_t                      rsp_q;

	logic                          full, empty;
	logic     [CMP_W-1:0]          pos_w, occ_w;
	logic                          ins, del_first, del_last, rd_ok;
	logic     [CNT_W-1:0]          slot, occ_d;
	logic     [1:0]                status;
	logic signed [63:0]            val_ext, rd_ext;
	logic     [DATA_WIDTH-1:0]     word;
	logic signed [DATA_WIDTH-1:0]  rd_word;
	logic     [IDX_W-1:0]          rd_idx;

	always_comb begin
		full      = (occ_q == CNT_W'(DEPTH));
		empty     = (occ_q == '0);
		pos_w     = CMP_W'(req_q.position);
		occ_w     = CMP_W'(occ_q);
		ins       = 1'b0;
		del_first = 1'b0;
		del_last  = 1'b0;
		rd_ok     = 1'b0;
		slot      = '0;
		status    = ST_OK;
		case (req_q.req_type)
			REQ_INS_FIRST: begin
				if (full) status = ST_FULL;
				else ins = 1'b1;
			end
			REQ_INS_LAST: begin
				slot = occ_q;
				if (full) status = ST_FULL;
				else ins = 1'b1;
			end
			REQ_INS_POS: begin
				slot = CNT_W'(pos_w - CMP_W'(1));
				if (pos_w == '0 || pos_w > occ_w + CMP_W'(1)) status = ST_BADPOS;
				else if (full) status = ST_FULL;
				else ins = 1'b1;
			end
			REQ_DEL_FIRST: begin
				if (empty) status = ST_EMPTY;
				else del_first = 1'b1;
			end
			REQ_DEL_LAST: begin
				if (empty) status = ST_EMPTY;
				else del_last = 1'b1;
			end
			REQ_READ_POS: begin
				if (empty) status = ST_EMPTY;
				else if (pos_w == '0 || pos_w > occ_w) status = ST_BADPOS;
				else rd_ok = 1'b1;
			end
			default: status = ST_OK;
		endcase

		occ_d = occ_q;
		if (ins) occ_d = occ_q + CNT_W'(1);
		else if (del_first || del_last) occ_d = occ_q - CNT_W'(1);

		val_ext = 64'(req_q.value);
		word    = val_ext[DATA_WIDTH-1:0];
		rd_idx  = IDX_W'(pos_w - CMP_W'(1));
		rd_word = cells_q[rd_idx];
		rd_ext  = rd_ok ? 64'(rd_word) : 64'sd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.exec) begin
			rsp_q.status     <= status;
			rsp_q.count      <= 5'(occ_d);
			rsp_q.read_value <= rd_ext[31:0];
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (ins) begin
					if (CNT_W'(i) == slot) cells_q[i] <= word;
					else if (CNT_W'(i) > slot) cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
				end else if (del_first && i < DEPTH - 1) begin
					cells_q[i] <= cells_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) occ_q <= '0;
		else if (cmd.exec) occ_q <= occ_d;
	end

	assign rsp = rsp_q;

endmodule

@@ src/positional_list_store.sv @@
// Top level of the positional list store: controller and datapath.
//
// channel   ports              handshake
// request   req (pls_req_t)    taken at clk rise when start && !busy
// result    rsp (pls_rsp_t)    valid for one cycle while done is high
//
// Each item is captured, then executed: in execute the affected cells of the
// chain all shift at once; done rises in the cycle after execute.
// A new item may be taken in the same cycle its predecessor's result shows.
// arst_n clears the count and the controller; cell contents are undefined.
// Results cannot be stalled; busy holds off requests during execute.
module positional_list_store (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pls_pkg::pls_req_t req,
	output logic              done,
	output pls_pkg::pls_rsp_t rsp
);
	import pls_pkg::*;

	pls_cmd_t cmd;

	pls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	pls_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

@@ src/pls_checker.sv @@
// Port-level assertions for the positional list store, bound to the top level.
module pls_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input pls_pkg::pls_rsp_t rsp
);
	import pls_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted item");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result strobe missing two cycles after accept");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.count <= 5'(DEPTH))
		else $error("count beyond list limit");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.read_value == 32'sd0)
		else $error("read_value nonzero on failed request");

endmodule

bind positional_list_store pls_checker u_pls_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
